@@ hw/rtl/rtq_pkg.sv @@
// ----------------------------------------------------------------------------
// rtq_pkg
// Shared types and constants of the retransmit timer queue.
// ----------------------------------------------------------------------------
package rtq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned ID_MODULUS = 100000;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned PTR_W = CNT_W + 1;

  localparam int unsigned ID_W       = 17;
  localparam int unsigned ID_CNT_W   = $clog2(ID_MODULUS);
  localparam int unsigned ID_NEED_W  = $clog2(ID_MODULUS + 1);
  localparam int unsigned ID_STORE_W = (ID_NEED_W > ID_W) ? ID_NEED_W : ID_W;

  localparam int unsigned PROD_W = 62;
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_CHECK  = 3'd1;
  localparam logic [2:0] OP_CANCEL = 3'd2;
  localparam logic [2:0] OP_INVOKE = 3'd3;
  localparam logic [2:0] OP_PEEK   = 3'd4;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_NONE = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]      operation;
    logic [63:0]     now_ns;
    logic [31:0]     delay_sec;
    logic [31:0]     delay_ns;
    logic [ID_W-1:0] target_id;
    logic            destroy;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] timer_id;
    logic [63:0]     created_ns;
    logic [31:0]     remaining_ns;
    logic            run_callback;
    logic            run_destroy;
  } rsp_t;

  typedef struct packed {
    logic [63:0]           deadline;
    logic [63:0]           created;
    logic [ID_STORE_W-1:0] id;
  } entry_t;

  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_NEXT = 2'd1,
    RD_SKIP = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    load_req;
    logic    clr_result;
    logic    calc_product;
    logic    append;
    logic    set_full;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    idx_clr;
    logic    idx_inc;
    logic    take_entry;
    logic    peek;
    logic    shift_wr;
    logic    pop;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       expired;
    logic       id_match;
    logic       more_next;
    logic       more_skip;
  } sts_t;

endpackage

@@ hw/rtl/retransmit_timer_queue_core.sv @@
// ----------------------------------------------------------------------------
// retransmit_timer_queue_core
// Bounded arrival-order queue of retransmission timers.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o carries one request (set, check expiry,
// cancel, invoke now, peek); output channel out_valid_o/out_ready_i returns
// exactly one response per request. Entries live in a single RAM with a
// registered read port, slot 0 being the head.
// Each request passes through dispatch and finish; a set on a queue that is not
// full also writes the new entry. Check and peek read the head unless the queue
// is empty; a check that finds the head expired takes it and moves every later
// entry up. Cancel and invoke search from the head and on a match move the later
// entries up to close the gap; the entries searched and moved never exceed the
// entry count. The search and the gap closing each take one RAM read per cycle.
// A new request is taken only once the previous one has finished; a finished
// response sits in the output register, so a stalled receiver holds back at
// most the completion of the next request.
// Reset empties the queue and sets the id counter so the first id is 2; the
// store itself is not cleared.
// ----------------------------------------------------------------------------
module retransmit_timer_queue_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rtq_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rtq_pkg::rsp_t out_data_o
);

  rtq_pkg::cmd_t cmd;
  rtq_pkg::sts_t sts;

  rtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rtq_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

endmodule

@@ hw/rtl/rtq_ram.sv @@
// ----------------------------------------------------------------------------
// rtq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rtq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/rtq_ctrl.sv @@
// ----------------------------------------------------------------------------
// rtq_ctrl
// Sequencer of the timer queue: decodes each transfer and steps the datapath.
// ----------------------------------------------------------------------------
module rtq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  rtq_pkg::sts_t sts_i,
  output rtq_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DISPATCH = 7'b0000010,
    ST_WRITE    = 7'b0000100,
    ST_HEAD     = 7'b0001000,
    ST_SEARCH   = 7'b0010000,
    ST_SHIFT    = 7'b0100000,
    ST_FINISH   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.rd_sel = rtq_pkg::RD_HEAD;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req   = 1'b1;
          cmd_o.clr_result = 1'b1;
          state_d          = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts_i.op)
          rtq_pkg::OP_SET: begin
            if (sts_i.full) begin
              cmd_o.set_full = 1'b1;
              state_d        = ST_FINISH;
            end else begin
              cmd_o.calc_product = 1'b1;
              state_d            = ST_WRITE;
            end
          end
          rtq_pkg::OP_CHECK, rtq_pkg::OP_PEEK: begin
            if (sts_i.empty) begin
              state_d = ST_FINISH;
            end else begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_sel  = rtq_pkg::RD_HEAD;
              cmd_o.idx_clr = 1'b1;
              state_d       = ST_HEAD;
            end
          end
          rtq_pkg::OP_CANCEL, rtq_pkg::OP_INVOKE: begin
            if (sts_i.empty) begin
              state_d = ST_FINISH;
            end else begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_sel  = rtq_pkg::RD_HEAD;
              cmd_o.idx_clr = 1'b1;
              state_d       = ST_SEARCH;
            end
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end
      ST_WRITE: begin
        cmd_o.append = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_HEAD: begin
        state_d = ST_FINISH;
        if (sts_i.op == rtq_pkg::OP_PEEK) begin
          cmd_o.peek = 1'b1;
        end else if (sts_i.expired) begin
          cmd_o.take_entry = 1'b1;
          if (sts_i.more_next) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = rtq_pkg::RD_NEXT;
            state_d      = ST_SHIFT;
          end else begin
            cmd_o.pop = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        if (sts_i.id_match) begin
          cmd_o.take_entry = 1'b1;
          if (sts_i.more_next) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = rtq_pkg::RD_NEXT;
            state_d      = ST_SHIFT;
          end else begin
            cmd_o.pop = 1'b1;
            state_d   = ST_FINISH;
          end
        end else if (sts_i.more_next) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_sel  = rtq_pkg::RD_NEXT;
          cmd_o.idx_inc = 1'b1;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        if (sts_i.more_skip) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = rtq_pkg::RD_SKIP;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/rtq_dp.sv @@
// ----------------------------------------------------------------------------
// rtq_dp
// Datapath of the timer queue: entry store, count, id counter and results.
// ----------------------------------------------------------------------------
module rtq_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rtq_pkg::req_t in_data_i,
  input  rtq_pkg::cmd_t cmd_i,
  output rtq_pkg::sts_t sts_o,
  output rtq_pkg::rsp_t out_data_o
);

  rtq_pkg::req_t req_q;
  rtq_pkg::rsp_t res_q, res_d;
  rtq_pkg::rsp_t out_q;
  logic [rtq_pkg::PROD_W-1:0]   prod_q;
  logic [rtq_pkg::CNT_W-1:0]    count_q, count_d;
  logic [rtq_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [rtq_pkg::ID_CNT_W-1:0] id_cnt_q, id_cnt_d;

  logic [rtq_pkg::ID_STORE_W-1:0] new_id;
  logic [rtq_pkg::PTR_W-1:0]      idx_ext;
  logic [rtq_pkg::PTR_W-1:0]      count_ext;
  logic [rtq_pkg::IDX_W-1:0]      raddr;
  logic [rtq_pkg::IDX_W-1:0]      waddr;
  logic                           we;
  rtq_pkg::entry_t                wdata;
  rtq_pkg::entry_t                rdata;
  logic [$bits(rtq_pkg::entry_t)-1:0] rdata_raw;

  assign rdata     = rtq_pkg::entry_t'(rdata_raw);
  assign new_id    = rtq_pkg::ID_STORE_W'(id_cnt_q) + rtq_pkg::ID_STORE_W'(1);
  assign idx_ext   = rtq_pkg::PTR_W'(idx_q);
  assign count_ext = rtq_pkg::PTR_W'(count_q);

  assign sts_o.op        = req_q.operation;
  assign sts_o.full      = (count_q == rtq_pkg::CNT_W'(rtq_pkg::DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.expired   = (rdata.deadline <= req_q.now_ns);
  assign sts_o.id_match  = (rdata.id == rtq_pkg::ID_STORE_W'(req_q.target_id));
  assign sts_o.more_next = ((idx_ext + rtq_pkg::PTR_W'(1)) < count_ext);
  assign sts_o.more_skip = ((idx_ext + rtq_pkg::PTR_W'(2)) < count_ext);

  always_comb begin
    case (cmd_i.rd_sel)
      rtq_pkg::RD_HEAD: raddr = '0;
      rtq_pkg::RD_NEXT: raddr = idx_q + rtq_pkg::IDX_W'(1);
      rtq_pkg::RD_SKIP: raddr = idx_q + rtq_pkg::IDX_W'(2);
      default:          raddr = '0;
    endcase
  end

  always_comb begin
    we    = cmd_i.append | cmd_i.shift_wr;
    waddr = idx_q;
    wdata = rdata;
    if (cmd_i.append) begin
      waddr          = count_q[rtq_pkg::IDX_W-1:0];
      wdata.deadline = req_q.now_ns + 64'(prod_q) + 64'(req_q.delay_ns);
      wdata.created  = req_q.now_ns;
      wdata.id       = new_id;
    end
  end

  rtq_ram #(
    .Width($bits(rtq_pkg::entry_t)),
    .Depth(rtq_pkg::DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  always_comb begin
    count_d  = count_q;
    idx_d    = idx_q;
    id_cnt_d = id_cnt_q;
    if (cmd_i.append) begin
      count_d  = count_q + rtq_pkg::CNT_W'(1);
      id_cnt_d = (id_cnt_q == rtq_pkg::ID_CNT_W'(rtq_pkg::ID_MODULUS - 1)) ? '0 :
                 id_cnt_q + rtq_pkg::ID_CNT_W'(1);
    end
    if (cmd_i.pop) begin
      count_d = count_q - rtq_pkg::CNT_W'(1);
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + rtq_pkg::IDX_W'(1);
    end
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.clr_result) begin
      res_d        = '0;
      res_d.status = rtq_pkg::STAT_NONE;
    end
    if (cmd_i.set_full) begin
      res_d.status = rtq_pkg::STAT_FULL;
    end
    if (cmd_i.append) begin
      res_d.status   = rtq_pkg::STAT_DONE;
      res_d.timer_id = new_id[rtq_pkg::ID_W-1:0];
    end
    if (cmd_i.peek) begin
      res_d.status       = rtq_pkg::STAT_DONE;
      res_d.remaining_ns = rdata.deadline[31:0] - req_q.now_ns[31:0];
    end
    if (cmd_i.take_entry) begin
      res_d.status       = rtq_pkg::STAT_DONE;
      res_d.timer_id     = rdata.id[rtq_pkg::ID_W-1:0];
      res_d.created_ns   = rdata.created;
      res_d.run_callback = (req_q.operation == rtq_pkg::OP_CHECK) ||
                           (req_q.operation == rtq_pkg::OP_INVOKE);
      res_d.run_destroy  = (req_q.operation == rtq_pkg::OP_CANCEL) && req_q.destroy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      id_cnt_q <= rtq_pkg::ID_CNT_W'(1);
    end else begin
      count_q  <= count_d;
      idx_q    <= idx_d;
      id_cnt_q <= id_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    if (cmd_i.calc_product) begin
      prod_q <= req_q.delay_sec * rtq_pkg::NS_PER_SEC;
    end
    res_q <= res_d;
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

endmodule
